>>> sv/nmea_line_rmc_position_parser_unit_assert.svh
// Assertion macros for the RMC position parser.
`ifndef NMEA_LINE_RMC_POSITION_PARSER_UNIT_ASSERT_SVH
`define NMEA_LINE_RMC_POSITION_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication check.
`define NRMC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nmea rmc parser check failed");

// Next-cycle implication check.
`define NRMC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nmea rmc parser check failed");

`endif

>>> sv/nmea_rmc_pkg.sv
// Shared types, constants and tables of the RMC position parser.
`default_nettype none
package nmea_rmc_pkg;
   localparam int ACC_W = 40;
   localparam int DEG_W = 10;
   localparam int Q_W   = 24;

   localparam logic [2:0] KIND_OTHER = 3'd0;
   localparam logic [2:0] KIND_CRW   = 3'd1;
   localparam logic [2:0] KIND_CRX   = 3'd2;
   localparam logic [2:0] KIND_CRZ   = 3'd3;
   localparam logic [2:0] KIND_ZDA   = 3'd4;
   localparam logic [2:0] KIND_RMC   = 3'd5;
   localparam logic [2:0] KIND_GGA   = 3'd6;

   localparam logic [71:0] PREFIX_TEXT [8] = '{
      72'("$PERDCRW,"), 72'("$PERDCRX,"), 72'("$PERDCRZ,"), 72'("$GPZDA,"),
      72'("$GNRMC,"), 72'("$GPRMC,"), 72'("$GNGGA,"), 72'("$GPGGA,")};
   localparam logic [3:0] PREFIX_LEN [8] = '{4'd9, 4'd9, 4'd9, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7};
   localparam logic [2:0] PREFIX_KIND [8] = '{KIND_CRW, KIND_CRX, KIND_CRZ, KIND_ZDA,
                                             KIND_RMC, KIND_RMC, KIND_GGA, KIND_GGA};

   // One finished line handed from the framer to the converter.
   typedef struct packed {
      logic [2:0]       kind;
      logic [6:0]       len;
      logic             silence;
      logic             fix;
      logic [ACC_W-1:0] lat_acc;
      logic [ACC_W-1:0] lon_acc;
      logic [1:0]       hemi;
   } line_type;

   function automatic logic [ACC_W-1:0] pow10(input logic [2:0] e);
      logic [ACC_W-1:0] r;
      unique case (e)
         3'd0: r = ACC_W'(1);
         3'd1: r = ACC_W'(10);
         3'd2: r = ACC_W'(100);
         3'd3: r = ACC_W'(1000);
         3'd4: r = ACC_W'(10000);
         3'd5: r = ACC_W'(100000);
         3'd6: r = ACC_W'(1000000);
         3'd7: r = ACC_W'(10000000);
         default: r = ACC_W'(1);
      endcase
      return r;
   endfunction

   // Character at position pos of prefix j; caller guarantees pos < length.
   function automatic logic [7:0] prefix_char(input logic [2:0] j, input logic [3:0] pos);
      logic [3:0] k;
      k = PREFIX_LEN[j] - 4'd1 - pos;
      return PREFIX_TEXT[j][{k, 3'b000} +: 8];
   endfunction
endpackage
`default_nettype wire

>>> sv/nmea_rmc_front.sv
// Line framer: prefix match, RMC field checks, coordinate accumulation, silence timer.
`default_nettype none
module nmea_rmc_front #(
   parameter int LINE_MAX = 128,
   parameter int FRAC     = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [7:0]              req_tdata,
   input  wire logic                    req_tuser,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [15:0]             csr_data,
   input  wire logic                    q_full,
   output logic                         q_push,
   output nmea_rmc_pkg::line_type       q_item
);
   localparam int LC_W  = $clog2(LINE_MAX);
   localparam int LCX   = (LC_W > 7) ? LC_W : 7;
   localparam int ACC_W = nmea_rmc_pkg::ACC_W;
   localparam int VW    = ACC_W + 4;
   localparam logic [ACC_W-1:0] POW_F = nmea_rmc_pkg::pow10(3'(FRAC));
   localparam logic [VW-1:0] CAP = VW'(100000) * VW'(POW_F);

   logic [15:0]      silence_ff, quiet_ff, quiet_in;
   logic [LC_W-1:0]  lc_ff, lc_in;
   logic [7:0]       cand_ff, cand_in;
   logic [4:0]       fn_ff, fn_in;
   logic [3:0]       fcc_ff, fcc_in;
   logic             ok_ff, ok_in;
   logic [ACC_W-1:0] lat_ff, lat_in, lon_ff, lon_in;
   logic [1:0]       hemi_ff, hemi_in;
   logic [1:0]       phase_ff, phase_in;
   logic [2:0]       frac_ff, frac_in;

   logic             fire, finish, by_sil;
   logic [7:0]       c;
   logic [ACC_W-1:0] acc_new;
   logic [2:0]       kind;
   logic [LCX-1:0]   lc_x;
   logic             is_digit;
   logic [VW-1:0]    v;

   assign req_tready = !q_full;
   assign csr_ready  = 1'b1;
   assign fire       = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign is_digit   = (c >= 8'h30) && (c <= 8'h39);

   // Number syntax step for the field being read.
   always_comb begin
      logic [ACC_W-1:0] cur;
      cur      = (fn_ff == 5'd3) ? lat_ff : lon_ff;
      v        = VW'(cur);
      phase_in = phase_ff;
      frac_in  = frac_ff;
      unique case (phase_ff)
         2'd0: begin
            if (is_digit) v = VW'(cur) * VW'(10) + VW'(c - 8'h30) * VW'(POW_F);
            else if (c == 8'h2e) phase_in = 2'd1;
            else phase_in = 2'd2;
         end
         2'd1: begin
            if (is_digit) begin
               if (frac_ff < 3'(FRAC)) begin
                  v = VW'(cur) + VW'(c - 8'h30)
                      * VW'(nmea_rmc_pkg::pow10(3'(FRAC - 1) - frac_ff));
                  frac_in = frac_ff + 3'd1;
               end
            end else begin
               phase_in = 2'd2;
            end
         end
         default: ;
      endcase
      acc_new = (v > CAP) ? ACC_W'(CAP) : v[ACC_W-1:0];
   end

   always_comb begin
      kind = nmea_rmc_pkg::KIND_OTHER;
      for (int j = 7; j >= 0; j--)
         if (cand_ff[j] && (LCX'(lc_ff) >= LCX'(nmea_rmc_pkg::PREFIX_LEN[j])))
            kind = nmea_rmc_pkg::PREFIX_KIND[j];
   end

   always_comb begin
      logic [4:0] f;
      f        = fn_ff;
      lc_in    = lc_ff;
      cand_in  = cand_ff;
      fn_in    = fn_ff;
      fcc_in   = fcc_ff;
      ok_in    = ok_ff;
      lat_in   = lat_ff;
      lon_in   = lon_ff;
      hemi_in  = hemi_ff;
      quiet_in = quiet_ff;
      finish   = 1'b0;
      by_sil   = 1'b0;
      if (fire && !req_tuser) begin
         quiet_in = '0;
         if (c == 8'h0a) begin
            finish = (lc_ff != '0);
         end else if (c != 8'h0d && lc_ff != LC_W'(LINE_MAX - 1)) begin
            for (int j = 0; j < 8; j++)
               if (LCX'(lc_ff) < LCX'(nmea_rmc_pkg::PREFIX_LEN[j]) &&
                   c != nmea_rmc_pkg::prefix_char(3'(j), lc_ff[3:0]))
                  cand_in[j] = 1'b0;
            if (c == 8'h2c) begin
               if (f <= 5'd6 && fcc_ff == 4'd0) ok_in = 1'b0;
               if (f == 5'd2 && fcc_ff != 4'd1) ok_in = 1'b0;
               if (fn_ff != 5'd31) fn_in = fn_ff + 5'd1;
               fcc_in = '0;
            end else begin
               if (f == 5'd2 && (fcc_ff != 4'd0 || c != 8'h41)) ok_in = 1'b0;
               if (f == 5'd3 || f == 5'd5) begin
                  if (fcc_ff == 4'd15) ok_in = 1'b0;
                  if (f == 5'd3) lat_in = acc_new;
                  else lon_in = acc_new;
               end
               if (f == 5'd4 && fcc_ff == 4'd3) ok_in = 1'b0;
               if ((f == 5'd4 || f == 5'd6) && fcc_ff == 4'd0 && (c == 8'h53 || c == 8'h57))
                  hemi_in = hemi_ff | ((f == 5'd4) ? 2'b01 : 2'b10);
               if (fcc_ff != 4'd15) fcc_in = fcc_ff + 4'd1;
            end
            lc_in = lc_ff + LC_W'(1);
         end
      end else if (fire) begin
         if (quiet_ff != 16'hffff) quiet_in = quiet_ff + 16'd1;
         if (lc_ff != '0 && quiet_in > silence_ff) begin
            finish = 1'b1;
            by_sil = 1'b1;
         end
      end
   end

   assign lc_x = LCX'(lc_ff);
   always_comb begin
      q_item.kind    = kind;
      q_item.len     = (lc_x > LCX'(127)) ? 7'd127 : lc_x[6:0];
      q_item.silence = by_sil;
      q_item.fix     = (kind == nmea_rmc_pkg::KIND_RMC) && ok_ff &&
                       (fn_ff > 5'd6 || (fn_ff == 5'd6 && fcc_ff != 4'd0));
      q_item.lat_acc = lat_ff;
      q_item.lon_acc = lon_ff;
      q_item.hemi    = hemi_ff;
   end
   assign q_push = finish;

   logic num_field, kept, is_comma;
   assign kept      = fire && !req_tuser && c != 8'h0a && c != 8'h0d &&
                      lc_ff != LC_W'(LINE_MAX - 1);
   assign is_comma  = c == 8'h2c;
   assign num_field = fn_ff == 5'd3 || fn_ff == 5'd5;

   always_ff @(posedge clock) begin
      if (reset) begin
         silence_ff <= 16'd100;
         quiet_ff   <= '0;
         lc_ff      <= '0;
         cand_ff    <= '1;
         fn_ff      <= '0;
         fcc_ff     <= '0;
         ok_ff      <= 1'b1;
         lat_ff     <= '0;
         lon_ff     <= '0;
         hemi_ff    <= '0;
         phase_ff   <= '0;
         frac_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) silence_ff <= csr_data;
         quiet_ff <= quiet_in;
         if (finish) begin
            lc_ff    <= '0;
            cand_ff  <= '1;
            fn_ff    <= '0;
            fcc_ff   <= '0;
            ok_ff    <= 1'b1;
            lat_ff   <= '0;
            lon_ff   <= '0;
            hemi_ff  <= '0;
            phase_ff <= '0;
            frac_ff  <= '0;
         end else begin
            lc_ff   <= lc_in;
            cand_ff <= cand_in;
            fn_ff   <= fn_in;
            fcc_ff  <= fcc_in;
            ok_ff   <= ok_in;
            lat_ff  <= lat_in;
            lon_ff  <= lon_in;
            hemi_ff <= hemi_in;
            if (kept && is_comma) begin
               phase_ff <= '0;
               frac_ff  <= '0;
            end else if (kept && num_field) begin
               phase_ff <= phase_in;
               frac_ff  <= frac_in;
            end
         end
      end
   end
endmodule
`default_nettype wire

>>> sv/nmea_rmc_fifo.sv
// Two-entry queue of finished lines between framer and converter.
`default_nettype none
module nmea_rmc_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire nmea_rmc_pkg::line_type push_item,
   input  wire logic                   pop,
   output nmea_rmc_pkg::line_type      pop_item,
   output logic                        full,
   output logic                        empty
);
   nmea_rmc_pkg::line_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_item = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

>>> sv/nmea_rmc_back.sv
// Converter: ddmm.mmmm accumulators to signed 1e-7 degrees, position store, result register.
`default_nettype none
module nmea_rmc_back #(
   parameter int FRAC = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_empty,
   input  wire nmea_rmc_pkg::line_type q_item,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [79:0]                 rsp_tdata
);
   localparam int ACC_W = nmea_rmc_pkg::ACC_W;
   localparam int DEG_W = nmea_rmc_pkg::DEG_W;
   localparam int Q_W   = nmea_rmc_pkg::Q_W;
   localparam int SH    = 8;
   localparam logic [ACC_W-1:0] UNIT  = ACC_W'(100) * nmea_rmc_pkg::pow10(3'(FRAC));
   localparam logic [ACC_W-1:0] MUL_P = nmea_rmc_pkg::pow10(3'(7 - FRAC));
   // degree estimate (acc >> SH) * DEG_RCP >> DEG_P is low by at most one
   localparam int DEG_P = $clog2(UNIT) + 3;
   localparam logic [12:0] DEG_RCP = 13'((64'd1 << (SH + DEG_P)) / 64'(UNIT));
   // exact floor(x / 60) for x below 2^30
   localparam logic [30:0] RCP60 = 31'd1145324613;
   localparam logic [33:0] E7_MAX = 34'd1800000000;

   typedef enum logic [2:0] {S_IDLE, S_LOAD, S_REM, S_FIX, S_MUL, S_QUO, S_SUM, S_OUT}
      state_type;

   state_type              state_ff;
   nmea_rmc_pkg::line_type item_ff;
   logic                   sel_ff;
   logic [ACC_W-1:0]       rem_ff;
   logic [DEG_W-1:0]       deg_ff;
   logic [Q_W-1:0]         q_ff;
   logic [31:0]            lat_ff, lon_ff;
   logic [1:0]             valid_ff;

   logic [ACC_W-1:0] acc_sel, deg_mul;
   logic [47:0]      deg_prod;
   logic [DEG_W-1:0] deg_est;
   logic [60:0]      quo_prod;
   logic [33:0]      e7_raw, e7;
   logic [31:0]      e7_signed;
   logic             neg;

   assign q_pop    = (state_ff == S_IDLE) && !q_empty;
   assign acc_sel  = sel_ff ? item_ff.lon_acc : item_ff.lat_acc;
   assign deg_prod = 48'(acc_sel[ACC_W-1:SH]) * 48'(DEG_RCP);
   assign deg_est  = DEG_W'(deg_prod >> DEG_P);
   assign deg_mul  = ACC_W'(deg_ff) * ACC_W'(UNIT[29:0]);
   assign quo_prod = 61'(rem_ff[29:0]) * 61'(RCP60);
   assign e7_raw   = 34'(deg_ff) * 34'd10000000 + 34'(q_ff);
   assign e7       = (e7_raw > E7_MAX) ? E7_MAX : e7_raw;
   assign neg      = sel_ff ? item_ff.hemi[1] : item_ff.hemi[0];
   assign e7_signed = neg ? 32'd0 - e7[31:0] : e7[31:0];

   assign rsp_tvalid = state_ff == S_OUT;
   assign rsp_tdata  = {2'b00, lon_ff, lat_ff, valid_ff[1], valid_ff[0], item_ff.fix,
                        item_ff.silence, item_ff.len, item_ff.kind};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= 1'b0;
         lat_ff   <= '0;
         lon_ff   <= '0;
         valid_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  item_ff  <= q_item;
                  sel_ff   <= 1'b0;
                  state_ff <= q_item.fix ? S_LOAD : S_OUT;
               end
            end
            S_LOAD: begin
               if (acc_sel == '0) begin
                  if (sel_ff) begin
                     lon_ff      <= '0;
                     valid_ff[1] <= 1'b0;
                     state_ff    <= S_OUT;
                  end else begin
                     lat_ff      <= '0;
                     valid_ff[0] <= 1'b0;
                     sel_ff      <= 1'b1;
                  end
               end else begin
                  rem_ff   <= acc_sel;
                  deg_ff   <= deg_est;
                  state_ff <= S_REM;
               end
            end
            S_REM: begin
               rem_ff   <= rem_ff - deg_mul;
               state_ff <= S_FIX;
            end
            S_FIX: begin
               // estimate may be one short
               if (rem_ff >= UNIT) begin
                  rem_ff <= rem_ff - UNIT;
                  deg_ff <= deg_ff + DEG_W'(1);
               end
               state_ff <= S_MUL;
            end
            S_MUL: begin
               rem_ff   <= ACC_W'(rem_ff[29:0]) * ACC_W'(MUL_P[23:0]);
               state_ff <= S_QUO;
            end
            S_QUO: begin
               q_ff     <= Q_W'(quo_prod >> 36);
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (sel_ff) begin
                  lon_ff      <= e7_signed;
                  valid_ff[1] <= 1'b1;
                  state_ff    <= S_OUT;
               end else begin
                  lat_ff      <= e7_signed;
                  valid_ff[0] <= 1'b1;
                  sel_ff      <= 1'b1;
                  state_ff    <= S_LOAD;
               end
            end
            S_OUT: begin
               if (rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> sv/nmea_line_rmc_position_parser_unit.sv
// Top level of the NMEA line framer and RMC position parser.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata rx_byte[7:0]; tuser func
//  rsp     | out | rsp_tvalid/rsp_tready | tdata kind, length, flags, lat, lon
//  csr     | in  | csr_valid/csr_ready   | csr_data silence_flush_ticks[15:0]
//
// The framer accepts a byte or tick whenever the queue is not full. A finished
// line waits in a two-entry queue. The converter takes each nonzero coordinate
// of an RMC fix through load, remainder, fix, multiply, quotient and sum steps,
// using reciprocal multiplications. req_tready drops only while the queue is
// full. Reset is synchronous; no clearing pass.
`default_nettype none
`include "nmea_line_rmc_position_parser_unit_assert.svh"
module nmea_line_rmc_position_parser_unit #(
   parameter int LINE_MAX               = 128,
   parameter int MINUTE_FRACTION_DIGITS = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] rx_byte
   input  wire logic        req_tuser,  // [0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] sentence_kind, [9:3] line_length, [10] by_silence, [11] fix_parsed,
   // [12] lat_valid, [13] lon_valid, [45:14] latitude_e7, [77:46] longitude_e7
   output logic [79:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   nmea_rmc_pkg::line_type push_item, pop_item;
   logic push, pop, full, empty;

   nmea_rmc_front #(.LINE_MAX(LINE_MAX), .FRAC(MINUTE_FRACTION_DIGITS)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .csr_valid, .csr_ready, .csr_data,
      .q_full(full), .q_push(push), .q_item(push_item));

   nmea_rmc_fifo u_fifo (
      .clock, .reset, .push, .push_item, .pop, .pop_item, .full, .empty);

   nmea_rmc_back #(.FRAC(MINUTE_FRACTION_DIGITS)) u_back (
      .clock, .reset, .q_empty(empty), .q_item(pop_item), .q_pop(pop),
      .rsp_tvalid, .rsp_tready, .rsp_tdata);

   `NRMC_ASSERT_NOW(a_no_overflow, clock, reset, push, !full)
   `NRMC_ASSERT_NOW(a_lat_zero, clock, reset, rsp_tvalid && !rsp_tdata[12],
      rsp_tdata[45:14] == 32'd0)
   `NRMC_ASSERT_NOW(a_lon_zero, clock, reset, rsp_tvalid && !rsp_tdata[13],
      rsp_tdata[77:46] == 32'd0)
   `NRMC_ASSERT_NEXT(a_pop_moves, clock, reset, pop && !push && !full, !full)
endmodule
`default_nettype wire

>>> tb/tb_nmea_line_rmc_position_parser_unit.sv
// Self-checking testbench for the NMEA line framer and RMC position parser.
`timescale 1ns / 100ps
`default_nettype none
module tb_nmea_line_rmc_position_parser_unit;
   localparam int TIMEOUT_CYCLES = 2_000_000;

   typedef struct packed {
      logic [31:0] lon;
      logic [31:0] lat;
      logic        lon_ok;
      logic        lat_ok;
      logic        fix;
      logic        silence;
      logic [6:0]  len;
      logic [2:0]  kind;
   } line_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   nmea_line_rmc_position_parser_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data));

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [15:0] flush_ticks;
   int unsigned kept_len, cand, fld, fld_chars, num_phase, frac_cnt;
   bit          layout_ok;
   longint unsigned lat_acc, lon_acc;
   bit [1:0]    hemi;
   int unsigned quiet;
   logic [31:0] lat_store, lon_store;
   bit [1:0]    pos_ok;

   line_report_type expected_lines[$];
   int  errors = 0;
   longint cycles = 0;
   bit  hold_off = 1'b0;
   int  gap_max = 3;

   const string PREFIXES[8] = '{"$PERDCRW,", "$PERDCRX,", "$PERDCRZ,", "$GPZDA,",
                                "$GNRMC,", "$GPRMC,", "$GNGGA,", "$GPGGA,"};
   const logic [2:0] KINDS[8] = '{nmea_rmc_pkg::KIND_CRW, nmea_rmc_pkg::KIND_CRX,
                                  nmea_rmc_pkg::KIND_CRZ, nmea_rmc_pkg::KIND_ZDA,
                                  nmea_rmc_pkg::KIND_RMC, nmea_rmc_pkg::KIND_RMC,
                                  nmea_rmc_pkg::KIND_GGA, nmea_rmc_pkg::KIND_GGA};

   function automatic longint unsigned pw10(int e);
      longint unsigned r = 1;
      for (int i = 0; i < e; i++) r *= 10;
      return r;
   endfunction

   function void clear_line();
      kept_len = 0; cand = 8'hFF; fld = 0; fld_chars = 0; layout_ok = 1;
      lat_acc = 0; lon_acc = 0; hemi = 0; num_phase = 0; frac_cnt = 0;
   endfunction

   function automatic longint unsigned digit_in(longint unsigned v, byte unsigned c);
      longint unsigned lim;
      bit dig;
      lim = 100000 * pw10(5);
      dig = c >= "0" && c <= "9";
      if (num_phase == 0) begin
         if (dig) v = v * 10 + (c - "0") * pw10(5);
         else if (c == ".") num_phase = 1;
         else num_phase = 2;
      end else if (num_phase == 1) begin
         if (dig) begin
            if (frac_cnt < 5) begin
               v += (c - "0") * pw10(4 - frac_cnt);
               frac_cnt++;
            end
         end else num_phase = 2;
      end
      return v > lim ? lim : v;
   endfunction

   function void keep_char(byte unsigned c);
      for (int j = 0; j < 8; j++)
         if (kept_len < PREFIXES[j].len() && c != PREFIXES[j][kept_len]) cand &= ~(1 << j);
      if (c == ",") begin
         if (fld <= 6) begin
            if (fld_chars == 0) layout_ok = 0;
            if (fld == 2 && fld_chars != 1) layout_ok = 0;
         end
         if (fld < 31) fld++;
         fld_chars = 0; num_phase = 0; frac_cnt = 0;
      end else begin
         if (fld == 2 && (fld_chars != 0 || c != "A")) layout_ok = 0;
         if (fld == 3 || fld == 5) begin
            if (fld_chars == 15) layout_ok = 0;
            if (fld == 3) lat_acc = digit_in(lat_acc, c);
            else lon_acc = digit_in(lon_acc, c);
         end
         if (fld == 4 && fld_chars == 3) layout_ok = 0;
         if ((fld == 4 || fld == 6) && fld_chars == 0 && (c == "S" || c == "W"))
            hemi |= (fld == 4) ? 2'b01 : 2'b10;
         if (fld_chars < 15) fld_chars++;
      end
      kept_len++;
   endfunction

   function automatic logic [31:0] to_e7(longint unsigned s, bit neg, output bit ok);
      longint unsigned deg, mins, e7;
      ok = s != 0;
      if (!ok) return 0;
      deg = s / (100 * pw10(5));
      mins = s - deg * 100 * pw10(5);
      e7 = deg * 10000000 + (mins * 10000000) / (60 * pw10(5));
      if (e7 > 1800000000) e7 = 1800000000;
      return neg ? -e7[31:0] : e7[31:0];
   endfunction

   function void finish_line(bit by_quiet);
      line_report_type r;
      bit ok;
      r.kind = nmea_rmc_pkg::KIND_OTHER;
      for (int j = 0; j < 8; j++)
         if (cand[j] && kept_len >= PREFIXES[j].len()) begin
            r.kind = KINDS[j];
            break;
         end
      r.fix = r.kind == nmea_rmc_pkg::KIND_RMC && layout_ok &&
              (fld > 6 || (fld == 6 && fld_chars >= 1));
      if (r.fix) begin
         lat_store = to_e7(lat_acc, hemi[0], ok); pos_ok[0] = ok;
         lon_store = to_e7(lon_acc, hemi[1], ok); pos_ok[1] = ok;
      end
      r.len = kept_len > 127 ? 7'd127 : kept_len[6:0];
      r.silence = by_quiet;
      r.lat_ok = pos_ok[0]; r.lon_ok = pos_ok[1];
      r.lat = lat_store; r.lon = lon_store;
      expected_lines.push_back(r);
      clear_line();
   endfunction

   function void predict_item(bit tick, byte unsigned c);
      if (!tick) begin
         quiet = 0;
         if (c == 8'h0A) begin
            if (kept_len > 0) finish_line(0);
         end else if (c != 8'h0D && kept_len < 127) keep_char(c);
      end else begin
         if (quiet < 65535) quiet++;
         if (kept_len > 0 && quiet > flush_ticks) finish_line(1);
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   // sender: bursts with random gaps; tvalid stays high inside a burst
   int burst_left = 0;
   task automatic send_item(bit tick, byte unsigned c);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, gap_max + 1)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_tvalid <= 1'b1; req_tuser <= tick; req_tdata <= c;
      do @(posedge clock); while (!req_tready);
      predict_item(tick, c);
      @(negedge clock);
      if (burst_left == 0) req_tvalid <= 1'b0;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(0, s[i]);
   endtask

   task automatic drain();
      if (burst_left != 0) begin
         burst_left = 0;
         req_tvalid <= 1'b0;
      end
      while (expected_lines.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_flush_ticks(logic [15:0] v);
      drain();
      csr_valid <= 1'b1; csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      flush_ticks = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver stall pattern, plus a long hold-off on request
   always @(negedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= (cycles % 64 < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT_CYCLES) begin
         $display("tb_nmea_line_rmc_position_parser_unit NOT OK");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      line_report_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[77:0];
         if (expected_lines.size() == 0) begin
            report_mismatch("unexpected line transfer", rsp_tdata[31:0], 32'd0);
         end else begin
            want = expected_lines.pop_front();
            if (got.kind != want.kind) report_mismatch("sentence_kind", got.kind, want.kind);
            if (got.len != want.len) report_mismatch("line_length", got.len, want.len);
            if (got.silence != want.silence)
               report_mismatch("by_silence", got.silence, want.silence);
            if (got.fix != want.fix) report_mismatch("fix_parsed", got.fix, want.fix);
            if (got.lat_ok != want.lat_ok) report_mismatch("lat_valid", got.lat_ok, want.lat_ok);
            if (got.lon_ok != want.lon_ok) report_mismatch("lon_valid", got.lon_ok, want.lon_ok);
            if (got.lat != want.lat) report_mismatch("latitude_e7", got.lat, want.lat);
            if (got.lon != want.lon) report_mismatch("longitude_e7", got.lon, want.lon);
         end
      end
   end

   function automatic string rand_digits(int n);
      string s = "";
      for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
      return s;
   endfunction

   function automatic string rand_coord(int int_digits);
      string s = rand_digits(int_digits);
      if ($urandom_range(0, 5) != 0) s = {s, ".", rand_digits($urandom_range(0, 8))};
      return s;
   endfunction

   function automatic string rand_rmc();
      string s, h1, h2;
      h1 = $urandom_range(0, 1) ? "N" : "S";
      h2 = $urandom_range(0, 1) ? "E" : "W";
      s = {$urandom_range(0, 1) ? "$GNRMC," : "$GPRMC,", rand_digits(6), ".00,",
           ($urandom_range(0, 7) == 0) ? "V" : "A", ",", rand_coord(4), ",", h1, ",",
           rand_coord($urandom_range(3, 5)), ",", h2};
      if ($urandom_range(0, 1)) s = {s, ",0.5,12.3,010203,,,A*", rand_digits(2)};
      return s;
   endfunction

   function automatic string rand_noise();
      string s = "";
      int n = $urandom_range(0, 20);
      for (int i = 0; i < n; i++) begin
         byte c = byte'($urandom_range(0, 255));
         if (c == 8'h0A) c = ",";
         s = {s, string'(c)};
      end
      return s;
   endfunction

   function automatic string mangle(string s);
      int p = $urandom_range(0, s.len() - 1);
      s[p] = byte'($urandom_range(32, 126));
      return s;
   endfunction

   task automatic test_directed();
      send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W\n");
      send_text("$GNRMC,1,A,0000.00000,S,00000,W\n");          // zero coordinates
      send_text("$GNRMC,1,A,9999999.99999999,S,18100.1,W\n");  // saturation
      send_text("$GNRMC,1,A,-12.5,N,1.2.3,E\n");               // number stops early
      send_text("$GNRMC,1,V,4807.038,N,01131.000,E\n");        // status not A
      send_text("$GNRMC,,A,4807.038,N,01131.000,E\n");         // empty field
      send_text("$GNRMC,1,A,1234567890123456,N,1,E\n");        // field too long
      send_text("$GNRMC,1,A,1,NNNN,1,E\n");
      send_text("$PERDCRW,x\r\n$PERDCRX,\n$PERDCRZ,\n$GPZDA,\n$GNGGA,\n$GPGGA,\n$GP\n");
      send_item(0, 8'h00); send_item(0, 8'hFF); send_item(0, 8'h0A);
      send_item(0, 8'h0A);
      for (int i = 0; i < 140; i++) send_item(0, "Z");           // long line
      send_item(0, 8'h0A);
      send_text("$GPGGA,partial");
      for (int i = 0; i < 102; i++) send_item(1, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_flush_settings();
      logic [15:0] vals[4] = '{16'd0, 16'd1, 16'd3, 16'd65535};
      foreach (vals[k]) begin
         write_flush_ticks(vals[k]);
         repeat (2) begin
            send_text(rand_rmc());
            for (int i = 0; i < 5; i++) send_item(1, 0);
            send_item(0, 8'h0A);
         end
      end
      write_flush_ticks(16'd100);
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (3000) @(negedge clock);
            hold_off = 1'b0;
         end
         repeat (6) send_text({rand_rmc(), "\n"});
      join
   endtask

   task automatic test_random();
      int sent = 0;
      write_flush_ticks(16'($urandom_range(2, 12)));
      while (sent < 450) begin
         string s;
         int pick = $urandom_range(0, 9);
         gap_max = $urandom_range(0, 1) ? 0 : 6;
         if (pick < 6) s = rand_rmc();
         else if (pick == 6) s = mangle(rand_rmc());
         else if (pick == 7) s = {PREFIXES[$urandom_range(0, 7)], rand_noise()};
         else s = rand_noise();
         send_text(s);
         sent += s.len();
         if ($urandom_range(0, 3) == 0) begin
            int n = $urandom_range(1, 16);
            for (int i = 0; i < n; i++) send_item(1, 8'($urandom_range(0, 255)));
            sent += n;
         end
         if ($urandom_range(0, 4) != 0) begin
            send_item(0, $urandom_range(0, 1) ? 8'h0D : 8'h0A);
            send_item(0, 8'h0A);
            sent += 2;
         end
      end
   endtask

   initial begin
      flush_ticks = 16'd100;
      clear_line();
      quiet = 0; lat_store = 0; lon_store = 0; pos_ok = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_flush_settings();
      test_backpressure();
      test_random();
      drain();
      if (errors == 0 && expected_lines.size() == 0)
         $display("tb_nmea_line_rmc_position_parser_unit OK");
      else
         $display("tb_nmea_line_rmc_position_parser_unit NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
